// File: hw/rtl/mrtu_pkg.sv
// ----------------------------------------------------------------------------
// mrtu_pkg
// shared types and constants for the modbus rtu write frame receiver
// ----------------------------------------------------------------------------
package mrtu_pkg;

  localparam logic [7:0]  FUNC_WRITE_MULTI = 8'h10;
  localparam logic [15:0] CRC_INIT         = 16'hFFFF;
  localparam logic [15:0] CRC_POLY         = 16'hA001;

  localparam logic [7:0]  STATION_ADDR_RST = 8'd132;
  localparam logic [7:0]  FULL_BLOCK_RST   = 8'd64;

  // configuration register indexes
  localparam logic CFG_STATION_ADDR = 1'b0;
  localparam logic CFG_FULL_BLOCK   = 1'b1;

  typedef enum logic [1:0] {
    EV_DATA    = 2'd0,
    EV_MORE    = 2'd1,
    EV_LAST    = 2'd2,
    EV_CRC_ERR = 2'd3
  } ev_kind_e;

  typedef enum logic [9:0] {
    PH_HUNT    = 10'b00_0000_0001,
    PH_FUNC    = 10'b00_0000_0010,
    PH_ADR_HI  = 10'b00_0000_0100,
    PH_ADR_LO  = 10'b00_0000_1000,
    PH_NREG_HI = 10'b00_0001_0000,
    PH_NREG_LO = 10'b00_0010_0000,
    PH_COUNT   = 10'b00_0100_0000,
    PH_DATA    = 10'b00_1000_0000,
    PH_CRC_LO  = 10'b01_0000_0000,
    PH_CRC_HI  = 10'b10_0000_0000
  } phase_e;

  typedef struct packed {
    ev_kind_e    kind;
    logic [7:0]  data_byte;
    logic [7:0]  data_index;
    logic [16:0] page_word_address;
    logic [7:0]  byte_count;
  } ev_t;

endpackage

// File: hw/rtl/mrtu_crc16_byte.sv
// ----------------------------------------------------------------------------
// mrtu_crc16_byte
// one-byte update of the modbus crc-16, reflected, eight shift steps unrolled
// ----------------------------------------------------------------------------
module mrtu_crc16_byte
  import mrtu_pkg::*;
(
  input  logic [15:0] crc_i,
  input  logic [7:0]  byte_i,
  output logic [15:0] crc_o
);

  always_comb begin
    logic [15:0] c;
    c = crc_i ^ {8'h00, byte_i};
    for (int i = 0; i < 8; i++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    crc_o = c;
  end

endmodule

// File: hw/rtl/mrtu_parser.sv
// ----------------------------------------------------------------------------
// mrtu_parser
// frame phase tracking, field capture, running crc and event building
// ----------------------------------------------------------------------------
module mrtu_parser
  import mrtu_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] byte_i,
  input  logic [7:0] station_address_i,
  input  logic [7:0] full_block_bytes_i,
  output logic       has_ev_o,
  output ev_t        ev_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] crc_q, crc_d;
  logic [15:0] addr_q, addr_d;
  logic [7:0]  count_q, count_d;
  logic [7:0]  dcnt_q, dcnt_d;
  logic [7:0]  crc_lo_q, crc_lo_d;

  logic [15:0] crc_base;
  logic [15:0] crc_next;
  logic [7:0]  dcnt_inc;

  // hunting restarts the crc from its initial value
  assign crc_base = (phase_q == PH_HUNT) ? CRC_INIT : crc_q;

  mrtu_crc16_byte u_crc (
    .crc_i  (crc_base),
    .byte_i (byte_i),
    .crc_o  (crc_next)
  );

  assign dcnt_inc = dcnt_q + 8'd1;
  assign has_ev_o = (phase_q == PH_DATA) || (phase_q == PH_CRC_HI);

  always_comb begin
    phase_d  = phase_q;
    crc_d    = crc_q;
    addr_d   = addr_q;
    count_d  = count_q;
    dcnt_d   = dcnt_q;
    crc_lo_d = crc_lo_q;

    ev_o.kind              = EV_DATA;
    ev_o.data_byte         = 8'h00;
    ev_o.data_index        = 8'h00;
    ev_o.page_word_address = {addr_q, 1'b0};
    ev_o.byte_count        = count_q;

    unique case (phase_q)
      PH_FUNC: begin
        crc_d   = crc_next;
        phase_d = (byte_i == FUNC_WRITE_MULTI) ? PH_ADR_HI : PH_HUNT;
      end
      PH_ADR_HI: begin
        crc_d   = crc_next;
        addr_d  = {byte_i, addr_q[7:0]};
        phase_d = PH_ADR_LO;
      end
      PH_ADR_LO: begin
        crc_d   = crc_next;
        addr_d  = {addr_q[15:8], byte_i};
        phase_d = PH_NREG_HI;
      end
      PH_NREG_HI: begin
        crc_d   = crc_next;
        phase_d = PH_NREG_LO;
      end
      PH_NREG_LO: begin
        crc_d   = crc_next;
        phase_d = PH_COUNT;
      end
      PH_COUNT: begin
        crc_d   = crc_next;
        count_d = byte_i;
        dcnt_d  = 8'h00;
        phase_d = (byte_i == 8'h00) ? PH_CRC_LO : PH_DATA;
      end
      PH_DATA: begin
        crc_d           = crc_next;
        ev_o.data_byte  = byte_i;
        ev_o.data_index = dcnt_q;
        dcnt_d          = dcnt_inc;
        if (dcnt_inc == count_q) begin
          phase_d = PH_CRC_LO;
        end
      end
      PH_CRC_LO: begin
        crc_lo_d = byte_i;
        phase_d  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        if ({byte_i, crc_lo_q} != crc_q) begin
          ev_o.kind = EV_CRC_ERR;
        end else if (count_q == full_block_bytes_i) begin
          ev_o.kind = EV_MORE;
        end else begin
          ev_o.kind = EV_LAST;
        end
        phase_d = PH_HUNT;
      end
      default: begin
        // hunting, and any code that means nothing
        phase_d = PH_HUNT;
        if (byte_i == station_address_i) begin
          crc_d   = crc_next;
          phase_d = PH_FUNC;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HUNT;
      crc_q    <= CRC_INIT;
      addr_q   <= 16'h0000;
      count_q  <= 8'h00;
      dcnt_q   <= 8'h00;
      crc_lo_q <= 8'h00;
    end else if (step_i) begin
      phase_q  <= phase_d;
      crc_q    <= crc_d;
      addr_q   <= addr_d;
      count_q  <= count_d;
      dcnt_q   <= dcnt_d;
      crc_lo_q <= crc_lo_d;
    end
  end

  // data phase never runs past the byte count
  a_dcnt_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA) |-> (dcnt_q < count_q))
    else $error("data counter reached byte count inside data phase");

  // a crc check always returns to hunting
  a_crc_hi_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (phase_q == PH_CRC_HI)) |=> (phase_q == PH_HUNT))
    else $error("parser did not return to hunting after crc check");

  // a zero byte count skips the data phase
  a_zero_count_skip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_i && (phase_q == PH_COUNT) && (byte_i == 8'h00)) |=> (phase_q == PH_CRC_LO))
    else $error("zero byte count entered data phase");

endmodule

// File: hw/rtl/modbus_rtu_write_frame_receiver.sv
// ----------------------------------------------------------------------------
// modbus_rtu_write_frame_receiver
// byte-stream parser for modbus rtu write multiple registers frames
// ----------------------------------------------------------------------------
// Received bytes enter on the rx channel, one request per byte. The block
// waits for the station address byte, then requires function code 0x10,
// captures the 16-bit page address and the byte count, gives out every data
// byte with its index, and after the crc (low byte first) reports a good
// frame with more to follow (count equals full_block_bytes), a good last
// frame, or a crc error, then hunts again. Sustained rate is one byte per
// clock while no event stalls on the ev channel: each byte is held in the
// input register and resolved there by the phase logic and an unrolled
// byte-wide crc-16 update; any event it makes goes out via the event register.
// Bytes that cause no event keep flowing while a finished event waits on a
// stalled ev channel; a byte that causes an event waits in the input register
// until the event register is free. Configuration writes take effect at once
// and are meant to be made while no frame is in flight.
// ----------------------------------------------------------------------------
module modbus_rtu_write_frame_receiver
  import mrtu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,

  // configuration write port
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [7:0]  cfg_data_i,

  // received byte requests
  input  logic        rx_valid_i,
  output logic        rx_ready_o,
  input  logic [7:0]  rx_byte_i,

  // event requests
  output logic        ev_valid_o,
  input  logic        ev_ready_i,
  output logic [1:0]  event_kind_o,
  output logic [7:0]  data_byte_o,
  output logic [7:0]  data_index_o,
  output logic [16:0] page_word_address_o,
  output logic [7:0]  byte_count_o
);

  // configuration registers
  logic [7:0] station_addr_q;
  logic [7:0] full_block_q;

  // input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;

  // event register
  logic       ev_valid_q;
  ev_t        ev_q;

  logic       has_ev;
  ev_t        ev_next;
  logic       ev_free;
  logic       step;
  logic       rx_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_addr_q <= STATION_ADDR_RST;
      full_block_q   <= FULL_BLOCK_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_STATION_ADDR: station_addr_q <= cfg_data_i;
        CFG_FULL_BLOCK:   full_block_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // event slot is free if empty or being drained this cycle
  assign ev_free = !ev_valid_q || ev_ready_i;

  // the held byte advances unless it makes an event with nowhere to go
  assign step       = in_valid_q && (!has_ev || ev_free);
  assign rx_ready_o = !in_valid_q || step;
  assign rx_fire    = rx_valid_i && rx_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= rx_fire || (in_valid_q && !step);
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire) begin
      in_byte_q <= rx_byte_i;
    end
  end

  mrtu_parser u_parser (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .step_i             (step),
    .byte_i             (in_byte_q),
    .station_address_i  (station_addr_q),
    .full_block_bytes_i (full_block_q),
    .has_ev_o           (has_ev),
    .ev_o               (ev_next)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_valid_q <= 1'b0;
    end else if (step && has_ev) begin
      ev_valid_q <= 1'b1;
    end else if (ev_ready_i) begin
      ev_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && has_ev) begin
      ev_q <= ev_next;
    end
  end

  assign ev_valid_o          = ev_valid_q;
  assign event_kind_o        = ev_q.kind;
  assign data_byte_o         = ev_q.data_byte;
  assign data_index_o        = ev_q.data_index;
  assign page_word_address_o = ev_q.page_word_address;
  assign byte_count_o        = ev_q.byte_count;

  // a held byte only stalls behind an undrained event
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && !step) |-> (has_ev && ev_valid_q && !ev_ready_i))
    else $error("input register stalled without a blocked event");

  // a stalled event is not overwritten
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ev_valid_q && !ev_ready_i) |-> !(step && has_ev))
    else $error("event register loaded while holding an undrained event");

  // an accepted byte is always held next cycle
  a_accept_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_fire |=> in_valid_q)
    else $error("accepted byte was lost");

endmodule

// File: dv/modbus_rtu_write_frame_receiver_test.sv
// ----------------------------------------------------------------------------
// modbus_rtu_write_frame_receiver_test
// Self-checking bench for the write multiple registers frame receiver. A short
// table of hand-built frames runs first. Random frames follow under several
// station address and block size settings. A byte-level frame parser inside
// the bench predicts every event that the table does not type in by hand, and
// each event on the ev channel is checked against the oldest prediction. The rx
// side sends in random bursts and the ev side stalls on its own pattern.
// ----------------------------------------------------------------------------
module modbus_rtu_write_frame_receiver_test;
  timeunit 1ns;
  timeprecision 1ps;

  import mrtu_pkg::*;

  localparam int CLK_HALF        = 6;
  localparam int RESET_CYCLES    = 12;
  localparam int NUM_SETTINGS    = 5;
  localparam int BYTES_PER_SETUP = 130;   // least number of frame bytes per register setting
  localparam int DRAIN_CYCLES    = 8;     // a byte's event passes the input register, then the event register
  localparam int RUN_LIMIT_NS    = 3_000_000;

  // where a table row takes its byte from
  typedef enum {
    SRC_LIT,
    SRC_CRC_LO,
    SRC_CRC_LO_BAD,
    SRC_CRC_HI
  } byte_src_e;

  typedef struct {
    logic [7:0] value;
    byte_src_e  src;
    bit         fixed;     // event typed in by hand
    ev_t        ev;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_idx_i;
  logic [7:0]  cfg_data_i;
  logic        rx_valid_i;
  logic        rx_ready_o;
  logic [7:0]  rx_byte_i;
  logic        ev_valid_o;
  logic        ev_ready_i;
  logic [1:0]  event_kind_o;
  logic [7:0]  data_byte_o;
  logic [7:0]  data_index_o;
  logic [16:0] page_word_address_o;
  logic [7:0]  byte_count_o;

  modbus_rtu_write_frame_receiver u_top (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_idx_i           (cfg_idx_i),
    .cfg_data_i          (cfg_data_i),
    .rx_valid_i          (rx_valid_i),
    .rx_ready_o          (rx_ready_o),
    .rx_byte_i           (rx_byte_i),
    .ev_valid_o          (ev_valid_o),
    .ev_ready_i          (ev_ready_i),
    .event_kind_o        (event_kind_o),
    .data_byte_o         (data_byte_o),
    .data_index_o        (data_index_o),
    .page_word_address_o (page_word_address_o),
    .byte_count_o        (byte_count_o)
  );

  // --------------------------------------------------------------------------
  // bench copy of the frame parser state and its two registers
  // --------------------------------------------------------------------------
  phase_e      fr_phase;
  logic [15:0] fr_crc;
  logic [15:0] fr_addr;
  logic [7:0]  fr_count;
  logic [7:0]  fr_index;
  logic [7:0]  fr_crc_lo;
  logic [7:0]  my_station;
  logic [7:0]  my_full_block;

  ev_t         pending_events[$];   // predicted events not yet seen on ev
  stim_row_t   directed_rows[$];
  int          mismatches      = 0;
  int          burst_left      = 0;
  int          frame_bytes_sent = 0;
  int          n_data = 0, n_more = 0, n_last = 0, n_crc_err = 0;

  // modbus crc-16, one byte, reflected polynomial
  function automatic logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  function automatic ev_t frame_event(ev_kind_e k, logic [7:0] b, logic [7:0] idx);
    ev_t e;
    e.kind              = k;
    e.data_byte         = b;
    e.data_index        = idx;
    e.page_word_address = {fr_addr, 1'b0};
    e.byte_count        = fr_count;
    return e;
  endfunction

  // advance the bench parser by one accepted byte
  task automatic parse_byte(input logic [7:0] b, output bit has_ev, output ev_t ev);
    has_ev = 1'b0;
    ev     = '0;
    case (fr_phase)
      PH_FUNC: begin
        fr_crc   = crc16_step(fr_crc, b);
        fr_phase = (b == FUNC_WRITE_MULTI) ? PH_ADR_HI : PH_HUNT;
      end
      PH_ADR_HI: begin
        fr_crc   = crc16_step(fr_crc, b);
        fr_addr  = {b, fr_addr[7:0]};
        fr_phase = PH_ADR_LO;
      end
      PH_ADR_LO: begin
        fr_crc   = crc16_step(fr_crc, b);
        fr_addr  = {fr_addr[15:8], b};
        fr_phase = PH_NREG_HI;
      end
      PH_NREG_HI: begin
        fr_crc   = crc16_step(fr_crc, b);
        fr_phase = PH_NREG_LO;
      end
      PH_NREG_LO: begin
        fr_crc   = crc16_step(fr_crc, b);
        fr_phase = PH_COUNT;
      end
      PH_COUNT: begin
        fr_crc   = crc16_step(fr_crc, b);
        fr_count = b;
        fr_index = 8'd0;
        fr_phase = (b == 8'd0) ? PH_CRC_LO : PH_DATA;
      end
      PH_DATA: begin
        fr_crc   = crc16_step(fr_crc, b);
        has_ev   = 1'b1;
        ev       = frame_event(EV_DATA, b, fr_index);
        fr_index = fr_index + 8'd1;
        if (fr_index == fr_count) fr_phase = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        fr_crc_lo = b;
        fr_phase  = PH_CRC_HI;
      end
      PH_CRC_HI: begin
        has_ev = 1'b1;
        if ({b, fr_crc_lo} != fr_crc) begin
          ev = frame_event(EV_CRC_ERR, 8'd0, 8'd0);
        end else if (fr_count == my_full_block) begin
          ev = frame_event(EV_MORE, 8'd0, 8'd0);
        end else begin
          ev = frame_event(EV_LAST, 8'd0, 8'd0);
        end
        fr_phase = PH_HUNT;
      end
      default: begin
        fr_phase = PH_HUNT;
        if (b == my_station) begin
          fr_crc   = crc16_step(CRC_INIT, b);
          fr_phase = PH_FUNC;
        end
      end
    endcase
  endtask

  task automatic note_mismatch(input string msg);
    if (mismatches < 10) $display("%0t mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  // one rx request; entered and left at a falling edge, valid stays high
  // into the next request unless a burst ends here
  task automatic push_byte(input logic [7:0] b, input bit fixed, input ev_t fixed_ev);
    bit  has_ev;
    ev_t ev;
    if (burst_left == 0) begin
      rx_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 6);
    end
    burst_left--;
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    @(posedge clk_i);
    while (!rx_ready_o) @(posedge clk_i);
    parse_byte(b, has_ev, ev);
    if (fixed) begin
      pending_events.push_back(fixed_ev);
    end else if (has_ev) begin
      pending_events.push_back(ev);
    end
    @(negedge clk_i);
  endtask

  task automatic add_row(input logic [7:0] v, input byte_src_e src, input bit fixed,
                         input ev_t ev);
    stim_row_t r;
    r.value = v;
    r.src   = src;
    r.fixed = fixed;
    r.ev    = ev;
    directed_rows.push_back(r);
  endtask

  // mostly well formed frames with random content, some noise and breakage
  task automatic send_random_frame();
    logic [7:0]  frame[$];
    logic [7:0]  b;
    logic [7:0]  cnt;
    logic [15:0] crc;
    int          r;
    int          n;
    // noise between frames, rarely the station address itself
    repeat ($urandom_range(0, 3)) begin
      b = 8'($urandom);
      if (b == my_station && $urandom_range(0, 9) != 0) b = ~b;
      push_byte(b, 1'b0, '0);
    end
    frame.push_back(($urandom_range(0, 19) == 0) ? 8'($urandom) : my_station);
    frame.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : FUNC_WRITE_MULTI);
    repeat (4) frame.push_back(8'($urandom));   // page address, register count
    r = $urandom_range(0, 99);
    if (r < 55) begin
      cnt = 8'($urandom_range(0, 6));
    end else if (r < 70) begin
      cnt = my_full_block;
    end else if (r < 97) begin
      cnt = 8'($urandom_range(7, 24));
    end else begin
      cnt = 8'($urandom);
    end
    frame.push_back(cnt);
    repeat (cnt) frame.push_back(8'($urandom));
    crc = CRC_INIT;
    foreach (frame[i]) crc = crc16_step(crc, frame[i]);
    if ($urandom_range(0, 3) == 0) crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    frame.push_back(crc[7:0]);
    frame.push_back(crc[15:8]);
    // now and then the frame breaks off early
    n = frame.size();
    if ($urandom_range(0, 19) == 0) n = $urandom_range(1, frame.size() - 1);
    for (int i = 0; i < n; i++) begin
      push_byte(frame[i], 1'b0, '0);
      frame_bytes_sent++;
    end
  endtask

  task automatic wait_idle(input int cycles);
    while (pending_events.size() != 0) @(negedge clk_i);
    repeat (cycles) @(negedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // clock and run limit
  // --------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #(CLK_HALF) clk_i = ~clk_i;
  end

  initial begin
    #(RUN_LIMIT_NS * 1ns);
    $display("timeout with %0d events outstanding", pending_events.size());
    $display("RESULT: ERROR");
    $finish;
  end

  // --------------------------------------------------------------------------
  // ev side: stalls follow modes picked at random, each held over a random run of cycles
  // --------------------------------------------------------------------------
  initial begin : ev_stall
    int   mode;
    int   mode_left;
    int   hold_left;
    int   tick;
    logic held;
    mode      = 0;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    held      = 1'b1;
    ev_ready_i = 1'b0;
    forever begin
      @(negedge clk_i);
      if (mode_left == 0) begin
        mode      = $urandom_range(0, 3);
        mode_left = $urandom_range(50, 300);
      end
      mode_left--;
      tick++;
      case (mode)
        0: ev_ready_i <= 1'b1;                            // no stall
        1: ev_ready_i <= (tick % 3 == 0);                 // ready only when tick is a multiple of three
        2: ev_ready_i <= ($urandom_range(0, 9) < 7);      // random
        default: begin                                    // long runs either way
          if (hold_left == 0) begin
            hold_left = $urandom_range(1, 20);
            held      = ~held;
          end
          hold_left--;
          ev_ready_i <= held;
        end
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // ev side checker: each accepted event against the oldest prediction
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin : ev_check
    ev_t got;
    ev_t want;
    if (rst_ni && ev_valid_o && ev_ready_i) begin
      got.kind              = ev_kind_e'(event_kind_o);
      got.data_byte         = data_byte_o;
      got.data_index        = data_index_o;
      got.page_word_address = page_word_address_o;
      got.byte_count        = byte_count_o;
      if (pending_events.size() == 0) begin
        note_mismatch($sformatf("unexpected event kind %0d byte %02h idx %0d",
                                got.kind, got.data_byte, got.data_index));
      end else begin
        want = pending_events.pop_front();
        if (got.kind != want.kind || got.data_byte != want.data_byte ||
            got.data_index != want.data_index ||
            got.page_word_address != want.page_word_address ||
            got.byte_count != want.byte_count) begin
          note_mismatch($sformatf(
            "exp kind %0d byte %02h idx %0d addr %05h cnt %0d, got %0d %02h %0d %05h %0d",
            want.kind, want.data_byte, want.data_index, want.page_word_address,
            want.byte_count, got.kind, got.data_byte, got.data_index,
            got.page_word_address, got.byte_count));
        end
        case (want.kind)
          EV_DATA: n_data++;
          EV_MORE: n_more++;
          EV_LAST: n_last++;
          default: n_crc_err++;
        endcase
      end
    end
  end

  // --------------------------------------------------------------------------
  // stimulus
  // --------------------------------------------------------------------------
  initial begin : stimulus
    logic [7:0] b;
    logic [7:0] set_station;
    logic [7:0] set_full;
    stim_row_t  row;

    rst_ni     = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_STATION_ADDR;
    cfg_data_i = 8'd0;
    rx_valid_i = 1'b0;
    rx_byte_i  = 8'd0;

    // bench parser starts where the block does out of reset
    fr_phase      = PH_HUNT;
    fr_crc        = CRC_INIT;
    fr_addr       = 16'd0;
    fr_count      = 8'd0;
    fr_index      = 8'd0;
    fr_crc_lo     = 8'd0;
    my_station    = STATION_ADDR_RST;
    my_full_block = FULL_BLOCK_RST;

    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // noise while hunting is dropped
    add_row(8'h00, SRC_LIT, 1'b0, '0);
    add_row(8'hFF, SRC_LIT, 1'b0, '0);
    // address, then the address again where the function code belongs:
    // back to hunting without taking it as a new address, so 0x10 is noise
    add_row(STATION_ADDR_RST, SRC_LIT, 1'b0, '0);
    add_row(STATION_ADDR_RST, SRC_LIT, 1'b0, '0);
    add_row(FUNC_WRITE_MULTI, SRC_LIT, 1'b0, '0);
    // zero byte count, top page address, broken crc
    add_row(STATION_ADDR_RST, SRC_LIT, 1'b0, '0);
    add_row(FUNC_WRITE_MULTI, SRC_LIT, 1'b0, '0);
    add_row(8'hFF, SRC_LIT, 1'b0, '0);
    add_row(8'hFF, SRC_LIT, 1'b0, '0);
    add_row(8'h00, SRC_LIT, 1'b0, '0);
    add_row(8'h01, SRC_LIT, 1'b0, '0);
    add_row(8'h00, SRC_LIT, 1'b0, '0);
    add_row(8'h00, SRC_CRC_LO_BAD, 1'b0, '0);
    add_row(8'h00, SRC_CRC_HI, 1'b1, '{EV_CRC_ERR, 8'h00, 8'h00, 17'h1FFFE, 8'h00});
    // page zero, two data bytes at both extremes, good crc, last frame
    add_row(STATION_ADDR_RST, SRC_LIT, 1'b0, '0);
    add_row(FUNC_WRITE_MULTI, SRC_LIT, 1'b0, '0);
    add_row(8'h00, SRC_LIT, 1'b0, '0);
    add_row(8'h00, SRC_LIT, 1'b0, '0);
    add_row(8'h00, SRC_LIT, 1'b0, '0);
    add_row(8'h01, SRC_LIT, 1'b0, '0);
    add_row(8'h02, SRC_LIT, 1'b0, '0);
    add_row(8'h00, SRC_LIT, 1'b1, '{EV_DATA, 8'h00, 8'h00, 17'h00000, 8'h02});
    add_row(8'hFF, SRC_LIT, 1'b1, '{EV_DATA, 8'hFF, 8'h01, 17'h00000, 8'h02});
    add_row(8'h00, SRC_CRC_LO, 1'b0, '0);
    add_row(8'h00, SRC_CRC_HI, 1'b1, '{EV_LAST, 8'h00, 8'h00, 17'h00000, 8'h02});

    // walk the table; crc rows pick up the parser's running crc
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      case (row.src)
        SRC_CRC_LO:     b = fr_crc[7:0];
        SRC_CRC_LO_BAD: b = ~fr_crc[7:0];
        SRC_CRC_HI:     b = fr_crc[15:8];
        default:        b = row.value;
      endcase
      push_byte(b, row.fixed, row.ev);
    end

    // random frames, first under reset values, then under fresh settings
    for (int s = 0; s < NUM_SETTINGS; s++) begin
      if (s > 0) begin
        case (s)
          1: begin set_station = 8'h00; set_full = 8'h00; end
          2: begin set_station = 8'hFF; set_full = 8'hFF; end
          3: begin set_station = 8'($urandom); set_full = 8'($urandom_range(0, 24)); end
          default: begin
            set_station = STATION_ADDR_RST;
            set_full    = 8'($urandom_range(0, 6));
          end
        endcase
        // registers change only with nothing in flight
        rx_valid_i <= 1'b0;
        wait_idle(DRAIN_CYCLES);
        cfg_we_i   <= 1'b1;
        cfg_idx_i  <= CFG_STATION_ADDR;
        cfg_data_i <= set_station;
        @(negedge clk_i);
        cfg_idx_i  <= CFG_FULL_BLOCK;
        cfg_data_i <= set_full;
        @(negedge clk_i);
        cfg_we_i   <= 1'b0;
        my_station    = set_station;
        my_full_block = set_full;
      end
      frame_bytes_sent = 0;
      while (frame_bytes_sent < BYTES_PER_SETUP) send_random_frame();
    end

    rx_valid_i <= 1'b0;
    wait_idle(2 * DRAIN_CYCLES);
    if (pending_events.size() != 0) begin
      note_mismatch($sformatf("%0d events never arrived", pending_events.size()));
    end

    $display("checked %0d data bytes, %0d more-follow, %0d last and %0d crc error frames",
             n_data, n_more, n_last, n_crc_err);
    $display("over %0d register settings, %0d mismatches", NUM_SETTINGS, mismatches);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// File: filelist.f
hw/rtl/mrtu_pkg.sv
hw/rtl/mrtu_crc16_byte.sv
hw/rtl/mrtu_parser.sv
hw/rtl/modbus_rtu_write_frame_receiver.sv
dv/modbus_rtu_write_frame_receiver_test.sv
